// ----- src/bnf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared constants and types for the batchnorm folding unit: fixed-point
// format, iteration widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package bnf_pkg;

    // fixed-point format of all data values
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int EPS_W     = 16;

    // variance + epsilon is exact in 32 bits
    localparam int DEN_W  = 32;
    // numerator width for the divide, radicand width before rounding up
    localparam int NUM_W  = DEN_W + FRAC_BITS;
    // root width, radicand width (even), shared subtractor width
    localparam int ROOT_W = (NUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SUB_W  = ROOT_W + 2;
    // iteration counter width
    localparam int CNT_W  = $clog2(NUM_W);

    // product widths: full 32x32 magnitude, shifted product, accumulator
    localparam int PROD_W = 2 * DATA_W;
    localparam int PSH_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W  = PSH_W + 2;

    // input beat packing
    localparam int IN_DATA_W = 192;

    // item kinds carried in s_tuser
    localparam logic OP_PARAM  = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQRT = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } bnf_state_t;

endpackage

// ----- src/batchnorm_fold_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batchnorm_fold_unit
// Folds batch normalization into convolution weights one output channel at
// a time: scale = gamma / sqrt(var + epsilon), folded bias and scaled weights.
// ----------------------------------------------------------------------------
// Parameter beat: bit-serial root, then bit-serial divide on the shared
// subtractor (data in Q16.16), then a multiply and accumulate for old_bias and
// one for mean; a zero denominator skips root and divide. Weight beat: one
// multiply and accumulate on the shared 32x32 multiplier, one item at a time.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn, synchronous, active low): epsilon 1, channel scale 0.
module batchnorm_fold_unit
    import bnf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // epsilon register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [EPS_W-1:0]     cfg_data,

    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // gamma[31:0] beta[63:32] mean[95:64] variance[126:96]
    // old_bias[158:127] weight[190:159], zero pad [191]
    input  logic [IN_DATA_W-1:0] s_tdata,
    // op[0]
    input  logic [0:0]           s_tuser,

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value[31:0]
    output logic [DATA_W-1:0]    m_tdata,
    // overflow[0]
    output logic [0:0]           m_tuser
);

    // input field unpacking
    logic signed [DATA_W-1:0] in_gamma;
    logic signed [DATA_W-1:0] in_beta;
    logic signed [DATA_W-1:0] in_mean;
    logic        [30:0]       in_variance;
    logic signed [DATA_W-1:0] in_old_bias;
    logic signed [DATA_W-1:0] in_weight;

    assign in_gamma    = s_tdata[31:0];
    assign in_beta     = s_tdata[63:32];
    assign in_mean     = s_tdata[95:64];
    assign in_variance = s_tdata[126:96];
    assign in_old_bias = s_tdata[158:127];
    assign in_weight   = s_tdata[190:159];

    // state
    bnf_state_t               state_reg, state_next;
    logic [EPS_W-1:0]         epsilon_reg;
    logic signed [DATA_W-1:0] scale_reg;
    logic                     op_reg;
    logic                     second_reg;
    logic                     gamma_neg_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [SUB_W-1:0]         rem_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DATA_W-1:0]        a1_reg;
    logic [DATA_W-1:0]        a2_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_value_reg;
    logic                     m_ovf_reg;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        magnitude = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_value_reg;
    assign m_tuser   = m_ovf_reg;

    logic s_fire;
    logic out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // denominator and radicand at accept
    logic [DEN_W-1:0] den;
    logic [RAD_W-1:0] rad_init;
    assign den      = DEN_W'(in_variance) + DEN_W'(epsilon_reg);
    assign rad_init = RAD_W'({den, {FRAC_BITS{1'b0}}});

    // shared compare-subtract unit for root and divide steps
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_diff;
    logic             sub_ge;
    always_comb begin
        if (state_reg == ST_SQRT) begin
            sub_a = {rem_reg[SUB_W-3:0], rad_reg[RAD_W-1 -: 2]};
            sub_b = {root_reg, 2'b01};
        end else begin
            sub_a = {rem_reg[SUB_W-2:0], num_reg[NUM_W-1]};
            sub_b = SUB_W'(root_reg);
        end
    end
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[SUB_W];

    logic [SUB_W-1:0] rem_step;
    assign rem_step = sub_ge ? sub_diff[SUB_W-1:0] : sub_a;

    // final quotient and scale saturation
    logic [NUM_W-1:0]  quot;
    logic [DATA_W-1:0] quot_neg;
    logic              quot_hi;
    logic              quot_min;
    logic [DATA_W-1:0] scale_next;
    logic              scale_sat;
    assign quot     = {num_reg[NUM_W-2:0], sub_ge};
    assign quot_neg = ~quot[DATA_W-1:0] + 1'b1;
    assign quot_hi  = |quot[NUM_W-1:DATA_W-1];
    assign quot_min = (quot[NUM_W-1:DATA_W-1] == (NUM_W-DATA_W+1)'(1))
                      && (quot[DATA_W-2:0] == '0);
    always_comb begin
        scale_sat = 1'b0;
        if (!gamma_neg_reg) begin
            scale_next = quot[DATA_W-1:0];
            if (quot_hi) begin
                scale_sat  = 1'b1;
                scale_next = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end else begin
            scale_next = quot_neg;
            if (quot_hi && !quot_min) begin
                scale_sat  = 1'b1;
                scale_next = {1'b1, {(DATA_W-1){1'b0}}};
            end
        end
    end

    // accumulator step and output saturation
    logic [ACC_W-1:0]        prod_ext;
    logic                    acc_sub;
    logic [ACC_W-DATA_W:0]   acc_hi;
    logic                    acc_fits;
    logic [DATA_W-1:0]       acc_sat;
    assign prod_ext = ACC_W'(prod_reg[PROD_W-1:FRAC_BITS]);
    assign acc_sub  = neg_reg ^ (second_reg && (op_reg == OP_PARAM));
    assign acc_hi   = acc_reg[ACC_W-1:DATA_W-1];
    assign acc_fits = (&acc_hi) || !(|acc_hi);
    assign acc_sat  = acc_fits ? acc_reg[DATA_W-1:0]
                    : (acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}});

    // multiplier operand
    logic [DATA_W-1:0] mul_src;
    assign mul_src = second_reg ? a2_reg : a1_reg;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0] == OP_WEIGHT || den == '0) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = second_reg ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            epsilon_reg <= EPS_W'(1);
            scale_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                epsilon_reg <= cfg_data;
            end
            if (state_reg == ST_IDLE && s_fire && s_tuser[0] == OP_PARAM && den == '0) begin
                scale_reg <= '0;
            end
            if (state_reg == ST_DIV && cnt_reg == '0) begin
                scale_reg <= scale_next;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_reg        <= s_tuser[0];
                    gamma_neg_reg <= in_gamma[DATA_W-1];
                    num_reg       <= {magnitude(in_gamma), {FRAC_BITS{1'b0}}};
                    rad_reg       <= rad_init;
                    root_reg      <= '0;
                    rem_reg       <= '0;
                    cnt_reg       <= CNT_W'(ROOT_W - 1);
                    a1_reg        <= in_old_bias;
                    if (s_tuser[0] == OP_WEIGHT) begin
                        a2_reg     <= in_weight;
                        second_reg <= 1'b1;
                        acc_reg    <= '0;
                        ovf_reg    <= 1'b0;
                    end else begin
                        a2_reg     <= in_mean;
                        second_reg <= 1'b0;
                        acc_reg    <= ACC_W'(in_beta);
                        ovf_reg    <= (den == '0);
                    end
                end
            end
            // one root bit per cycle
            ST_SQRT: begin
                root_reg <= {root_reg[ROOT_W-2:0], sub_ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    cnt_reg <= CNT_W'(NUM_W - 1);
                    rem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                    rem_reg <= rem_step;
                end
            end
            // one quotient bit per cycle, quotient shifts into the numerator
            ST_DIV: begin
                rem_reg <= rem_step;
                num_reg <= quot;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    ovf_reg <= ovf_reg | scale_sat;
                end
            end
            // shared 32x32 magnitude multiply
            ST_MUL: begin
                prod_reg <= PROD_W'(magnitude(mul_src)) * PROD_W'(magnitude(scale_reg));
                neg_reg  <= mul_src[DATA_W-1] ^ scale_reg[DATA_W-1];
            end
            ST_ACC: begin
                acc_reg    <= acc_sub ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
                second_reg <= 1'b1;
            end
            // hand result to output register
            ST_DONE: begin
                if (out_free) begin
                    m_value_reg <= acc_sat;
                    m_ovf_reg   <= ovf_reg | !acc_fits;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- bench/batchnorm_fold_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batchnorm_fold_unit_test
// Self-checking bench for the batchnorm folding unit. A short directed run
// covers the field extremes, saturation and the zero denominator, then
// well-formed channels (one parameter beat and a few weight beats) mixed with
// noise beats under several epsilon values and idling patterns. Every
// accepted beat is predicted in fixed point and every result beat checked.
// ----------------------------------------------------------------------------
module batchnorm_fold_unit_test;
    import bnf_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_BEATS  = 410;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE   = 32'sd65536;

    typedef struct {
        logic              op;
        logic signed [31:0] gamma;
        logic signed [31:0] beta;
        logic signed [31:0] mean;
        logic [30:0]        variance;
        logic signed [31:0] old_bias;
        logic signed [31:0] weight;
    } fold_beat_t;

    typedef struct {
        logic signed [31:0] value;
        logic               overflow;
    } fold_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [EPS_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;

    // predictor state, mirrors the block after reset
    logic [EPS_W-1:0]   epsilon_now = 16'd1;
    logic signed [31:0] scale_now   = '0;

    fold_beat_t   beat_backlog[$];
    fold_result_t folded_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req     = 0;
    int stall_seen    = 0;
    int stall_left    = 0;
    bit in_taken      = 1'b0;

    int cycle_count   = 0;
    int mismatches    = 0;
    int beats_taken   = 0;
    int param_beats   = 0;
    int saturations   = 0;
    int eps_writes    = 0;

    batchnorm_fold_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------
    // fixed-point arithmetic of the fold
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        rem  = x;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // product truncated toward zero, not saturated
    function automatic longint trunc_mul(input longint a, input longint b);
        logic [63:0] p;
        p = (magnitude(a) * magnitude(b)) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v, inout logic ovf);
        if (v > longint'(S32_MAX)) begin
            ovf = 1'b1;
            return S32_MAX;
        end
        if (v < longint'(S32_MIN)) begin
            ovf = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    // expected result of one beat; a parameter beat also updates the scale
    function automatic fold_result_t fold_beat(input fold_beat_t b);
        fold_result_t r;
        logic [63:0]  den;
        logic [63:0]  root;
        logic [63:0]  quo;
        longint       sum;
        r.overflow = 1'b0;
        if (b.op == OP_PARAM) begin
            den = 64'(b.variance) + 64'(epsilon_now);
            if (den == 0) begin
                r.overflow = 1'b1;
                scale_now  = '0;
            end else begin
                root = int_sqrt(den << FRAC_BITS);
                quo  = (magnitude(longint'(b.gamma)) << FRAC_BITS) / root;
                scale_now = clamp32((b.gamma < 0) ? -longint'(quo) : longint'(quo),
                                    r.overflow);
            end
            sum = trunc_mul(longint'(b.old_bias), longint'(scale_now))
                - trunc_mul(longint'(b.mean), longint'(scale_now))
                + longint'(b.beta);
            r.value = clamp32(sum, r.overflow);
        end else begin
            r.value = clamp32(trunc_mul(longint'(b.weight), longint'(scale_now)),
                              r.overflow);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus shaping
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] shaped_word();
        logic signed [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: return w;
            1: begin
                case ($urandom_range(0, 2))
                    0: return S32_MAX;
                    1: return S32_MIN;
                    default: return '0;
                endcase
            end
            // within a few units of Q16.16
            2, 3: return $urandom_range(0, 2**18) - 2**17;
            default: return w >>> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [30:0] shaped_variance();
        logic [30:0] v;
        v = 31'($urandom);
        case ($urandom_range(0, 5))
            0: return v;
            1: return ($urandom_range(0, 1) != 0) ? 31'h7fffffff : 31'd0;
            2, 3: return 31'($urandom_range(0, 2**18));
            default: return v >> $urandom_range(0, 30);
        endcase
    endfunction

    // fields the op does not use carry random junk
    function automatic fold_beat_t make_param(input logic signed [31:0] g,
                                              input logic signed [31:0] b,
                                              input logic signed [31:0] m,
                                              input logic [30:0] v,
                                              input logic signed [31:0] ob);
        fold_beat_t it;
        it.op       = OP_PARAM;
        it.gamma    = g;
        it.beta     = b;
        it.mean     = m;
        it.variance = v;
        it.old_bias = ob;
        it.weight   = $urandom;
        return it;
    endfunction

    function automatic fold_beat_t make_weight(input logic signed [31:0] w);
        fold_beat_t it;
        it.op       = OP_WEIGHT;
        it.gamma    = $urandom;
        it.beta     = $urandom;
        it.mean     = $urandom;
        it.variance = 31'($urandom);
        it.old_bias = $urandom;
        it.weight   = w;
        return it;
    endfunction

    // mostly whole channels, some fully random beats
    task automatic queue_random(input int count);
        fold_beat_t it;
        int         n;
        int         k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 80) begin
                beat_backlog.push_back(make_param(shaped_word(), shaped_word(),
                                                  shaped_word(), shaped_variance(),
                                                  shaped_word()));
                n++;
                k = $urandom_range(1, 8);
                repeat (k) begin
                    beat_backlog.push_back(make_weight(shaped_word()));
                    n++;
                end
            end else begin
                it          = make_weight($urandom);
                it.op       = 1'($urandom_range(0, 1));
                beat_backlog.push_back(it);
                n++;
            end
        end
    endtask

    // checks at rising edges, returns at a falling edge once every beat is back
    task automatic wait_idle();
        @(posedge aclk);
        while (beat_backlog.size() != 0 || s_tvalid || folded_q.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // called at a falling edge
    task automatic write_epsilon(input logic [EPS_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        eps_writes++;
    endtask

    // ------------------------------------------------------------------
    // driver: offers backlog beats at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        fold_beat_t it;
        if (aresetn && !(s_tvalid && !in_taken)) begin
            if (beat_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = beat_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, it.weight, it.old_bias, it.variance,
                             it.mean, it.beta, it.gamma};
                s_tuser  <= it.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with a long hold-off on request
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = STALL_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result beats, predicts accepted input beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        fold_beat_t   b;
        fold_result_t want;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (folded_q.size() == 0) begin
                    $error("result beat with nothing pending: value %h overflow %b",
                           m_tdata, m_tuser[0]);
                    mismatches++;
                end else begin
                    want = folded_q.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("value: expected %h, got %h", want.value, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.overflow) begin
                        $error("overflow: expected %b, got %b", want.overflow, m_tuser[0]);
                        mismatches++;
                    end
                end
            end

            // input beat
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                b.op       = s_tuser[0];
                b.gamma    = s_tdata[31:0];
                b.beta     = s_tdata[63:32];
                b.mean     = s_tdata[95:64];
                b.variance = s_tdata[126:96];
                b.old_bias = s_tdata[158:127];
                b.weight   = s_tdata[190:159];
                want = fold_beat(b);
                folded_q.push_back(want);
                beats_taken++;
                if (b.op == OP_PARAM) param_beats++;
                if (want.overflow) saturations++;
            end

            if (cfg_valid && cfg_ready) epsilon_now = cfg_data;
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $error("timeout after %0d cycles, %0d results pending", cycle_count,
               folded_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial begin
        int base;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // weights before any channel see the reset scale of zero
        beat_backlog.push_back(make_weight(S32_MAX));
        beat_backlog.push_back(make_weight(S32_MIN));
        // unit scale: d = 1.0 with the reset epsilon
        beat_backlog.push_back(make_param(Q_ONE, '0, '0, 31'd65535, Q_ONE));
        beat_backlog.push_back(make_weight(S32_MAX));
        beat_backlog.push_back(make_weight(S32_MIN));
        // saturated scale, both signs, with extreme bias terms
        beat_backlog.push_back(make_param(S32_MAX, S32_MAX, S32_MIN, 31'd0, S32_MAX));
        beat_backlog.push_back(make_weight(S32_MAX));
        beat_backlog.push_back(make_weight(S32_MIN));
        beat_backlog.push_back(make_weight('0));
        beat_backlog.push_back(make_param(S32_MIN, S32_MIN, S32_MAX, 31'd0, S32_MIN));
        beat_backlog.push_back(make_weight(32'sd1));
        beat_backlog.push_back(make_weight(-32'sd1));
        // zero gamma at the largest variance leaves just beta
        beat_backlog.push_back(make_param('0, 32'sh5a5a_a5a5, S32_MAX, 31'h7fffffff,
                                          S32_MIN));
        // ordinary channel, ignored fields all ones
        begin
            fold_beat_t it;
            it = make_param(-32'sd98304, -32'sd16384, 32'sd32768, 31'd262144,
                            32'sd131072);
            it.weight = '1;
            beat_backlog.push_back(it);
            it = make_weight(-32'sd196608);
            it.gamma    = '1;
            it.beta     = '1;
            it.mean     = '1;
            it.variance = '1;
            it.old_bias = '1;
            beat_backlog.push_back(it);
        end
        wait_idle();

        // zero denominator needs epsilon 0 and variance 0
        write_epsilon(16'd0);
        beat_backlog.push_back(make_param(Q_ONE, 32'sh1234_5678, Q_ONE, 31'd0, Q_ONE));
        beat_backlog.push_back(make_weight(S32_MAX));
        beat_backlog.push_back(make_param(Q_ONE, '0, '0, 31'd1, Q_ONE));
        beat_backlog.push_back(make_weight(32'sd65536));
        wait_idle();

        // sender rarely idles, receiver mostly stalls
        write_epsilon(16'hffff);
        send_idle_pct = 12;
        recv_idle_pct = 85;
        queue_random(PHASE_BEATS);
        wait_idle();

        // sender mostly idles, receiver rarely stalls
        write_epsilon(16'($urandom_range(0, 65535)));
        send_idle_pct = 85;
        recv_idle_pct = 12;
        queue_random(PHASE_BEATS);
        wait_idle();

        // full rate, with one long receiver hold-off to back up the input
        write_epsilon(16'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base = beats_taken;
        queue_random(PHASE_BEATS);
        wait (beats_taken >= base + 20);
        stall_req++;
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d beats: %0d channel parameter, %0d weight, %0d saturated",
                 beats_taken, param_beats, beats_taken - param_beats, saturations);
        $display("%0d epsilon writes, %0d mismatches, %0d cycles",
                 eps_writes, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bnf_pkg.sv
src/batchnorm_fold_unit.sv
bench/batchnorm_fold_unit_test.sv
